@@ src/sle_pkg.sv @@
// shared request and status codes plus the control/status bundles
// used between the list engine controller and datapath
// no dependencies
package sle_pkg;

   // request kinds carried in req_tuser
   localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [2:0] OP_POP_BACK   = 3'd1;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd2;
   localparam logic [2:0] OP_POP_FRONT  = 3'd3;
   localparam logic [2:0] OP_INSERT     = 3'd4;
   localparam logic [2:0] OP_ERASE      = 3'd5;
   localparam logic [2:0] OP_FIND       = 3'd6;

   // result status carried in rsp_tuser
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_BADPOS   = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned POS_W   = 8;
   localparam int unsigned COUNT_W = 9;

   typedef struct packed {
      logic       load_req;   // capture transaction, clear result
      logic       start_walk; // set up read pointer for shift or find
      logic       walk;       // advance the walk one step
      logic       put;        // write request value, count up
      logic       cnt_dec;    // count down
      logic       set_st;     // overwrite result status
      logic [2:0] st;
      logic       hit;        // latch index of matching entry
      logic       emit;       // load output register
   } sle_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       full;
      logic       empty;
      logic       bad_pos;
      logic       busy;       // reads or a write still in flight
      logic       match;
      logic       out_free;
   } sle_sts_type;

endpackage

@@ src/sle_ctrl.sv @@
// controller state machine of the list engine
// sequences check, shift, find and write phases; depends on sle_pkg
module sle_ctrl
   import sle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  sle_sts_type sts,
   output sle_cmd_type cmd
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_SHIFT = 6'b000100,
      S_FIND  = 6'b001000,
      S_PUT   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.st    = ST_OK;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_DONE;
            case (sts.op)
               OP_PUSH_BACK: begin
                  if (sts.full) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = ST_FULL;
                  end else begin
                     state_in = S_PUT;
                  end
               end
               OP_POP_BACK: begin
                  if (sts.empty) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = ST_EMPTY;
                  end else begin
                     cmd.cnt_dec = 1'b1;
                  end
               end
               OP_PUSH_FRONT: begin
                  if (sts.full) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = ST_FULL;
                  end else if (sts.empty) begin
                     state_in = S_PUT;
                  end else begin
                     cmd.start_walk = 1'b1;
                     state_in       = S_SHIFT;
                  end
               end
               OP_POP_FRONT: begin
                  if (sts.empty) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = ST_EMPTY;
                  end else begin
                     cmd.start_walk = 1'b1;
                     state_in       = S_SHIFT;
                  end
               end
               OP_INSERT: begin
                  if (sts.bad_pos) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = ST_BADPOS;
                  end else if (sts.full) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = ST_FULL;
                  end else begin
                     cmd.start_walk = 1'b1;
                     state_in       = S_SHIFT;
                  end
               end
               OP_ERASE: begin
                  if (sts.empty) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = ST_EMPTY;
                  end else if (sts.bad_pos) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = ST_BADPOS;
                  end else begin
                     cmd.start_walk = 1'b1;
                     state_in       = S_SHIFT;
                  end
               end
               OP_FIND: begin
                  if (sts.empty) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = ST_NOTFOUND;
                  end else begin
                     cmd.start_walk = 1'b1;
                     state_in       = S_FIND;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SHIFT: begin
            cmd.walk = 1'b1;
            if (!sts.busy) begin
               // shift up leaves a hole for the new value, shift down just shrinks
               if (sts.op == OP_PUSH_FRONT || sts.op == OP_INSERT) begin
                  state_in = S_PUT;
               end else begin
                  cmd.cnt_dec = 1'b1;
                  state_in    = S_DONE;
               end
            end
         end
         S_FIND: begin
            cmd.walk = 1'b1;
            if (sts.match) begin
               cmd.hit  = 1'b1;
               state_in = S_DONE;
            end else if (!sts.busy) begin
               cmd.set_st = 1'b1;
               cmd.st     = ST_NOTFOUND;
               state_in   = S_DONE;
            end
         end
         S_PUT: begin
            cmd.put  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ src/sle_dp.sv @@
// datapath of the list engine: entry store, count, walk pointer,
// read pipeline and output register; depends on sle_pkg
module sle_dp
   import sle_pkg::*;
#(
   parameter int unsigned LIST_DEPTH = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [2:0]                req_op,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [POS_W-1:0]          req_pos,
   input  sle_cmd_type               cmd,
   output sle_sts_type               sts,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_status,
   output logic [POS_W-1:0]          rsp_found,
   output logic [COUNT_W-1:0]        rsp_count
);

   localparam int unsigned ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int unsigned EXT_W  = (CNT_W > POS_W + 1) ? CNT_W : POS_W + 1;

   logic signed [VALUE_W-1:0] mem [LIST_DEPTH];

   logic [2:0]                op_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [POS_W-1:0]          pos_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [ADDR_W-1:0]         rptr_ff, rptr_in;
   logic                      ract_ff, ract_in;
   logic                      dvld_ff;
   logic [ADDR_W-1:0]         daddr_ff;
   logic signed [VALUE_W-1:0] ddata_ff;
   logic [2:0]                st_ff;
   logic [ADDR_W-1:0]         found_ff;
   logic                      rsp_valid_ff;
   logic [2:0]                rsp_status_ff;
   logic [POS_W-1:0]          rsp_found_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;

   logic                      dir_up;
   logic [EXT_W-1:0]          first_ext;
   logic [EXT_W-1:0]          count_ext;
   logic [ADDR_W-1:0]         first_a;
   logic [ADDR_W-1:0]         top_a;
   logic                      rd_last;
   logic                      rd_en;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic signed [VALUE_W-1:0] wr_data;

   assign dir_up    = (op_ff == OP_PUSH_FRONT) || (op_ff == OP_INSERT);
   assign count_ext = EXT_W'(count_ff);
   assign first_ext = (op_ff == OP_INSERT || op_ff == OP_ERASE) ? EXT_W'(pos_ff) : '0;
   assign first_a   = ADDR_W'(first_ext);
   assign top_a     = ADDR_W'(count_ff - CNT_W'(1));
   assign rd_last   = dir_up ? (rptr_ff == first_a) : (rptr_ff == top_a);
   assign rd_en     = cmd.walk && ract_ff;

   // walk pointer: shift up reads downward, shift down and find read upward
   always_comb begin
      rptr_in = rptr_ff;
      ract_in = ract_ff;
      if (cmd.start_walk) begin
         if (op_ff == OP_FIND) begin
            rptr_in = '0;
            ract_in = 1'b1;
         end else if (dir_up) begin
            rptr_in = top_a;
            ract_in = 1'b1;
         end else begin
            rptr_in = ADDR_W'(first_ext + EXT_W'(1));
            ract_in = (first_ext + EXT_W'(1)) < count_ext;
         end
      end else if (rd_en) begin
         rptr_in = dir_up ? rptr_ff - ADDR_W'(1) : rptr_ff + ADDR_W'(1);
         ract_in = !rd_last;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.put) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = ddata_ff;
      if (cmd.put) begin
         wr_en   = 1'b1;
         wr_data = value_ff;
         case (op_ff)
            OP_PUSH_BACK: wr_addr = ADDR_W'(count_ff);
            OP_INSERT:    wr_addr = first_a;
            default:      wr_addr = '0;
         endcase
      end else if (cmd.walk && dvld_ff && op_ff != OP_FIND) begin
         wr_en   = 1'b1;
         wr_addr = dir_up ? daddr_ff + ADDR_W'(1) : daddr_ff - ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         ddata_ff <= mem[rptr_ff];
         daddr_ff <= rptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ract_ff      <= 1'b0;
         dvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ract_ff  <= ract_in;
         dvld_ff  <= rd_en;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rptr_ff <= rptr_in;
      if (cmd.load_req) begin
         op_ff    <= req_op;
         value_ff <= req_value;
         pos_ff   <= req_pos;
         st_ff    <= ST_OK;
         found_ff <= '0;
      end else begin
         if (cmd.set_st) begin
            st_ff <= cmd.st;
         end
         if (cmd.hit) begin
            found_ff <= daddr_ff;
         end
      end
      if (cmd.emit) begin
         rsp_status_ff <= st_ff;
         rsp_found_ff  <= POS_W'(found_ff);
         rsp_count_ff  <= COUNT_W'(count_ff);
      end
   end

   assign sts.op       = op_ff;
   assign sts.full     = count_ff == CNT_W'(LIST_DEPTH);
   assign sts.empty    = count_ff == '0;
   assign sts.bad_pos  = EXT_W'(pos_ff) >= count_ext;
   assign sts.busy     = ract_ff || dvld_ff;
   assign sts.match    = dvld_ff && (ddata_ff == value_ff);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

@@ src/sequential_list_engine_top.sv @@
// Ordered list of signed 32-bit words held in a single store of LIST_DEPTH entries.
// Each transaction carries one request (push/pop at either end, insert, erase,
// find) and returns exactly one result with status, found index and new count.
// The store allows one read and one write per cycle, and that sets the timing.
// Pop back, the unused code and any refused request finish without touching the
// store; push back and push front onto an empty list write one entry; insert,
// push front, pop front and erase move entries one at a time; a find reads
// entries from index 0 until it hits or reaches the end of the list.
// rsp_tvalid rises in the same cycle in which req_tready rises for the next transaction.
// A result that is not taken holds the engine before its output step. A new
// transaction is still taken while the previous result waits in the output register.
// depends on sle_pkg, sle_ctrl, sle_dp
module sequential_list_engine_top
   import sle_pkg::*;
#(
   parameter int unsigned LIST_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value [31:0], position [39:32]
   input  logic [2:0]  req_tuser,   // req_type [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // found_index [7:0], count [16:8], zero [23:17]
   output logic [2:0]  rsp_tuser    // status [2:0]
);

   sle_cmd_type        cmd;
   sle_sts_type        sts;
   logic [POS_W-1:0]   rsp_found;
   logic [COUNT_W-1:0] rsp_count;

   sle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sle_dp #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_tuser),
      .req_value  (req_tdata[31:0]),
      .req_pos    (req_tdata[39:32]),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (rsp_tuser),
      .rsp_found  (rsp_found),
      .rsp_count  (rsp_count)
   );

   assign rsp_tdata = {7'b0, rsp_count, rsp_found};

endmodule

@@ src/sle_checker.sv @@
// port-level checks for the list engine, bound to the top level
// depends on sle_pkg and sequential_list_engine_top
module sle_checker
   import sle_pkg::*;
#(
   parameter int unsigned LIST_DEPTH = 256
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_OK || rsp_tuser == ST_FULL || rsp_tuser == ST_EMPTY ||
                      rsp_tuser == ST_BADPOS || rsp_tuser == ST_NOTFOUND))
      else $error("bad status code");

   // only a successful find reports an index
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata[7:0] == 8'd0)
      else $error("index on failed request");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && LIST_DEPTH < 512 |-> 32'(rsp_tdata[16:8]) <= LIST_DEPTH)
      else $error("count above capacity");

   // a full answer means the list was already at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FULL && LIST_DEPTH < 512
         |-> 32'(rsp_tdata[16:8]) == LIST_DEPTH)
      else $error("full status below capacity");

endmodule

bind sequential_list_engine_top sle_checker #(
   .LIST_DEPTH (LIST_DEPTH)
) u_sle_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ dv/testbench.sv @@
// self-checking bench for sequential_list_engine_top: directed and random list requests,
// predicted in-bench and compared per field against the response stream
// depends on sle_pkg and sequential_list_engine_top
`timescale 1ns / 1ps

module testbench;
   import sle_pkg::*;

   localparam int unsigned LIST_DEPTH     = 256;
   localparam int          RANDOM_ITEMS   = 1800;
   localparam int          WATCHDOG_LIMIT = 6000;
   localparam int          DRAIN_CYCLES   = 300;
   localparam int          MAX_PRINTED    = 40;

   // request code the block does not define; it must answer ok and change nothing
   localparam logic [2:0] OP_UNUSED = 3'd7;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] value;
      logic [7:0]         position;
   } list_request_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] found_index;
      logic [8:0] count;
   } list_answer_type;

   typedef enum logic [1:0] {MIX_GROW, MIX_SHRINK, MIX_CHURN, MIX_FILL} mix_type;
   typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SLOW, RX_PERIODIC} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // value [31:0], position [39:32]
   logic [2:0]  req_tuser = '0;   // req_type [2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // found_index [7:0], count [16:8], zero [23:17]
   logic [2:0]  rsp_tuser;        // status [2:0]

   sequential_list_engine_top #(.LIST_DEPTH(LIST_DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // list image kept in step with accepted transactions
   logic [31:0]   stored_words [LIST_DEPTH];
   int            stored_count = 0;
   int            peak_count = 0;

   list_request_type pending_requests[$];
   list_answer_type  expected_answers[$];

   int error_count = 0;
   int accepted_total = 0;
   int checked_total = 0;
   int directed_total = 0;
   int status_seen [5] = '{0, 0, 0, 0, 0};
   logic req_taken = 1'b0;

   function automatic list_answer_type apply_list_request(logic [2:0] op, logic [31:0] value,
                                                          logic [7:0] pos);
      list_answer_type ans;
      int k;
      logic hit;
      ans.status = ST_OK;
      ans.found_index = '0;
      hit = 1'b0;
      case (op)
         OP_PUSH_BACK: begin
            if (stored_count >= LIST_DEPTH) ans.status = ST_FULL;
            else begin
               stored_words[stored_count] = value;
               stored_count++;
            end
         end
         OP_POP_BACK: begin
            if (stored_count == 0) ans.status = ST_EMPTY;
            else stored_count--;
         end
         OP_PUSH_FRONT: begin
            if (stored_count >= LIST_DEPTH) ans.status = ST_FULL;
            else begin
               for (k = stored_count; k > 0; k--) stored_words[k] = stored_words[k - 1];
               stored_words[0] = value;
               stored_count++;
            end
         end
         OP_POP_FRONT: begin
            if (stored_count == 0) ans.status = ST_EMPTY;
            else begin
               for (k = 0; k + 1 < stored_count; k++) stored_words[k] = stored_words[k + 1];
               stored_count--;
            end
         end
         OP_INSERT: begin
            // position is checked before fullness
            if (pos >= stored_count) ans.status = ST_BADPOS;
            else if (stored_count >= LIST_DEPTH) ans.status = ST_FULL;
            else begin
               for (k = stored_count; k > pos; k--) stored_words[k] = stored_words[k - 1];
               stored_words[pos] = value;
               stored_count++;
            end
         end
         OP_ERASE: begin
            if (stored_count == 0) ans.status = ST_EMPTY;
            else if (pos >= stored_count) ans.status = ST_BADPOS;
            else begin
               for (k = pos; k + 1 < stored_count; k++) stored_words[k] = stored_words[k + 1];
               stored_count--;
            end
         end
         OP_FIND: begin
            ans.status = ST_NOTFOUND;
            for (k = 0; k < stored_count && !hit; k++) begin
               if (stored_words[k] == value) begin
                  hit = 1'b1;
                  ans.status = ST_OK;
                  ans.found_index = k[7:0];
               end
            end
         end
         default: ;
      endcase
      if (stored_count > peak_count) peak_count = stored_count;
      ans.count = stored_count[8:0];
      return ans;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (error_count < MAX_PRINTED)
         $display("%0t: result %0d %s: got %0d, want %0d", $realtime, checked_total, what,
                  got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------- stimulus shaping

   function automatic int op_weight(mix_type mix, logic [2:0] op);
      case (mix)
         MIX_SHRINK:
            case (op)
               OP_PUSH_BACK: return 5;   OP_POP_BACK:  return 25;
               OP_PUSH_FRONT: return 5;  OP_POP_FRONT: return 20;
               OP_INSERT: return 5;      OP_ERASE:     return 30;
               OP_FIND: return 8;        default:      return 2;
            endcase
         MIX_CHURN:
            case (op)
               OP_PUSH_BACK: return 14;  OP_POP_BACK:  return 14;
               OP_PUSH_FRONT: return 14; OP_POP_FRONT: return 14;
               OP_INSERT: return 15;     OP_ERASE:     return 15;
               OP_FIND: return 12;       default:      return 2;
            endcase
         default:
            case (op)
               OP_PUSH_BACK: return 30;  OP_POP_BACK:  return 5;
               OP_PUSH_FRONT: return 20; OP_POP_FRONT: return 3;
               OP_INSERT: return 25;     OP_ERASE:     return 5;
               OP_FIND: return 10;       default:      return 2;
            endcase
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return -1;
               default: return '0;
            endcase
         1, 2, 3: return $urandom_range(0, 8) - 4;  // narrow range gives duplicate entries
         default: return $urandom;
      endcase
   endfunction

   function automatic list_request_type make_request(mix_type mix);
      list_request_type rq;
      int r, acc, o;
      logic chosen;
      r = $urandom_range(0, 99);
      acc = 0;
      chosen = 1'b0;
      rq.op = OP_UNUSED;
      for (o = 0; o < 8; o++) begin
         acc += op_weight(mix, o[2:0]);
         if (!chosen && r < acc) begin
            rq.op = o[2:0];
            chosen = 1'b1;
         end
      end
      rq.value = pick_value();
      rq.position = 8'($urandom_range(0, 255));
      if ((rq.op == OP_INSERT || rq.op == OP_ERASE) && stored_count > 0
          && $urandom_range(0, 9) < 8) begin
         case ($urandom_range(0, 5))
            0: rq.position = '0;
            1: rq.position = 8'(stored_count - 1);
            default: rq.position = 8'($urandom_range(0, stored_count - 1));
         endcase
      end
      if (rq.op == OP_FIND && stored_count > 0 && $urandom_range(0, 9) < 7)
         rq.value = stored_words[$urandom_range(0, stored_count - 1)];
      return rq;
   endfunction

   task automatic queue_request(logic [2:0] op, logic [31:0] value, logic [7:0] pos);
      list_request_type rq;
      rq.op = op;
      rq.value = value;
      rq.position = pos;
      pending_requests.push_back(rq);
   endtask

   // keep the driver fed while letting the list image catch up for shaping
   task automatic wait_for_room();
      while (pending_requests.size() > 1) @(negedge clock);
   endtask

   // ---------------------------------------------------------------- driver

   list_request_type next_request;
   int burst_left = 1;
   int gap_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            next_request = pending_requests.pop_front();
            req_tdata <= {next_request.position, next_request.value};
            req_tuser <= next_request.op;
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   rx_mode_type rx_mode = RX_STREAM;
   int          rx_mode_left = 0;
   int          rx_tick = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(50, 400);
         end else begin
            rx_mode_left--;
         end
         rx_tick++;
         case (rx_mode)
            RX_STREAM:   rsp_tready <= 1'b1;
            RX_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
            RX_SLOW:     rsp_tready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: rsp_tready <= (rx_tick[3:1] != 3'd0);
            default:     rsp_tready <= 1'b1;
         endcase
      end
   end

   // ---------------------------------------------------------------- monitor and checker

   list_answer_type want_answer;

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            expected_answers.push_back(
               apply_list_request(req_tuser, req_tdata[31:0], req_tdata[39:32]));
            accepted_total++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_answers.size() == 0) begin
               report_mismatch("arrived with nothing outstanding, status", rsp_tuser, -1);
            end else begin
               want_answer = expected_answers.pop_front();
               if (rsp_tuser !== want_answer.status)
                  report_mismatch("status", rsp_tuser, want_answer.status);
               if (rsp_tdata[7:0] !== want_answer.found_index)
                  report_mismatch("found_index", rsp_tdata[7:0], want_answer.found_index);
               if (rsp_tdata[16:8] !== want_answer.count)
                  report_mismatch("count", rsp_tdata[16:8], want_answer.count);
               if (rsp_tdata[23:17] !== 7'd0)
                  report_mismatch("padding", rsp_tdata[23:17], 0);
               if (want_answer.status <= ST_NOTFOUND) status_seen[want_answer.status]++;
            end
            checked_total++;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired: %0d requests outstanding", expected_answers.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int      random_issued;
      int      fills_done;
      int      seg_len;
      mix_type mix;
      random_issued = 0;
      fills_done = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty-list refusals and the undefined request code
      queue_request(OP_POP_BACK, 32'd0, 8'd0);
      queue_request(OP_POP_FRONT, 32'd0, 8'd0);
      queue_request(OP_ERASE, 32'd0, 8'd0);
      queue_request(OP_INSERT, 32'h1234_5678, 8'd0);
      queue_request(OP_FIND, 32'd0, 8'd0);
      queue_request(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF);
      // value extremes at both ends
      queue_request(OP_PUSH_BACK, 32'h7FFF_FFFF, 8'hFF);
      queue_request(OP_PUSH_FRONT, 32'h8000_0000, 8'd0);
      queue_request(OP_PUSH_BACK, -1, 8'd0);
      queue_request(OP_INSERT, 32'd0, 8'd1);
      queue_request(OP_INSERT, 32'd5, 8'd4);          // position equal to count
      queue_request(OP_INSERT, 32'd123, 8'd3);
      queue_request(OP_FIND, -1, 8'd0);
      queue_request(OP_FIND, 32'h8000_0000, 8'd0);
      queue_request(OP_FIND, 32'd5, 8'd0);
      queue_request(OP_ERASE, 32'd0, 8'hFF);
      queue_request(OP_ERASE, 32'd0, 8'd4);
      queue_request(OP_ERASE, 32'd0, 8'd0);
      queue_request(OP_UNUSED, 32'd0, 8'd0);
      queue_request(OP_POP_FRONT, 32'd0, 8'd0);
      queue_request(OP_POP_BACK, 32'd0, 8'd0);
      // duplicates: find must return the first match
      queue_request(OP_PUSH_BACK, 32'd7, 8'd0);
      queue_request(OP_PUSH_FRONT, 32'd7, 8'd0);
      queue_request(OP_FIND, 32'd7, 8'd0);
      directed_total = pending_requests.size();

      while (random_issued < RANDOM_ITEMS) begin
         if (fills_done < 2 && random_issued >= 500 + fills_done * 800) begin
            mix = MIX_FILL;
         end else begin
            mix = mix_type'($urandom_range(0, 2));
         end
         if (mix == MIX_FILL) begin
            // grow to capacity, then work against the full list
            while (stored_count < LIST_DEPTH) begin
               wait_for_room();
               pending_requests.push_back(make_request(MIX_GROW));
               random_issued++;
            end
            repeat (24) begin
               wait_for_room();
               pending_requests.push_back(make_request(MIX_CHURN));
               random_issued++;
            end
            fills_done++;
         end else begin
            seg_len = $urandom_range(40, 160);
            repeat (seg_len) begin
               wait_for_room();
               pending_requests.push_back(make_request(mix));
               random_issued++;
            end
         end
      end

      while (pending_requests.size() != 0 || req_tvalid || expected_answers.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d requests (%0d directed), %0d responses checked, peak length %0d/%0d",
               accepted_total, directed_total, checked_total, peak_count, LIST_DEPTH);
      $display("outcomes: ok %0d, full %0d, empty %0d, bad position %0d, not found %0d",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
               status_seen[ST_BADPOS], status_seen[ST_NOTFOUND]);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ sequential_list_engine_top.f @@
src/sle_pkg.sv
src/sle_ctrl.sv
src/sle_dp.sv
src/sequential_list_engine_top.sv
src/sle_checker.sv
dv/testbench.sv
